### design/eeg_test_packet_framer_assert.svh
// Assertion macros shared by the test packet framer modules.
`ifndef EEG_TEST_PACKET_FRAMER_ASSERT_SVH
`define EEG_TEST_PACKET_FRAMER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EEG_TPF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define EEG_TPF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/eeg_tpf_pkg.sv
// Shared types, codes and constants of the test packet framer.
package eeg_tpf_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int FRAMES_DEF   = 2;
    localparam int MAX_FRAMES   = 2;
    localparam int NEG_FIRST_CH = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int SAMPLE_W    = 24;
    localparam int AMP_W       = 23;
    localparam int HP_W        = 8;
    localparam int UNITS_W     = 12;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [7:0] FRAME_HEAD = 8'hA0;
    localparam logic [7:0] FRAME_TAIL = 8'hC0;

    // Command characters: 'b' begin, 's' stop, 'd' stop and sleep.
    localparam logic [7:0] CMD_BEGIN = 8'h62;
    localparam logic [7:0] CMD_STOP  = 8'h73;
    localparam logic [7:0] CMD_SLEEP = 8'h64;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_INTERVAL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_INTERVAL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_INTERVAL = 3'd4;

    localparam logic [AMP_W-1:0]   AMPLITUDE_RST      = 23'd4000000;
    localparam logic [HP_W-1:0]    HALF_PERIOD_RST    = 8'd25;
    localparam logic [UNITS_W-1:0] FAST_INTERVAL_RST  = 12'd6;
    localparam logic [UNITS_W-1:0] IDLE_INTERVAL_RST  = 12'd80;
    localparam logic [UNITS_W-1:0] SLEEP_INTERVAL_RST = 12'd800;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_COMMAND    = 2'd1,
        OP_CONNECT    = 2'd2,
        OP_DISCONNECT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } t_back_state;

    // One unit of work for the emitter: an interval request or a whole frame.
    typedef struct packed {
        logic                  is_request;
        logic [UNITS_W-1:0]    units;
        logic [7:0]            seq;
        logic [MAX_FRAMES-1:0] odd;
    } t_job;

endpackage

### design/eeg_tpf_front.sv
// Front end: accepts input transactions, tracks link state and builds jobs.
`include "eeg_test_packet_framer_assert.svh"

module eeg_tpf_front #(
    parameter int FRAMES_PER_PACKET = eeg_tpf_pkg::FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [7:0]                        i_command_byte,
    input  logic [eeg_tpf_pkg::HP_W-1:0]      i_half_period,
    input  logic [eeg_tpf_pkg::UNITS_W-1:0]   i_fast_interval,
    input  logic [eeg_tpf_pkg::UNITS_W-1:0]   i_idle_interval,
    input  logic [eeg_tpf_pkg::UNITS_W-1:0]   i_sleep_interval,
    input  logic                              i_q_full,
    output logic                              o_push,
    output eeg_tpf_pkg::t_job                 o_push_job
);

    localparam int CW     = eeg_tpf_pkg::COUNT_W;
    localparam int HW     = eeg_tpf_pkg::HP_W;
    localparam int UW     = eeg_tpf_pkg::UNITS_W;
    localparam int MAXF   = eeg_tpf_pkg::MAX_FRAMES;
    localparam int STEP_W = $clog2(CW);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CW - 1);

    eeg_tpf_pkg::t_front_state r_state, n_state;

    logic                         r_link_up, n_link_up;
    logic                         r_streaming_on, n_streaming_on;
    logic [7:0]                   r_frame_sequence, n_frame_sequence;
    logic [CW-1:0]                r_sample_count, n_sample_count;
    logic [STEP_W-1:0]            r_step;
    logic [7:0]                   r_seq_job;
    logic [FRAMES_PER_PACKET-1:0] r_odd;
    logic [CW-1:0]                r_dvd [FRAMES_PER_PACKET];
    logic [HW-1:0]                r_rem [FRAMES_PER_PACKET];

    logic          accept;
    logic          tick_go;
    logic          req_push;
    logic [UW-1:0] req_units;
    logic [HW-1:0] divisor;

    logic [HW:0]                  lane_partial [FRAMES_PER_PACKET];
    logic [HW:0]                  lane_diff    [FRAMES_PER_PACKET];
    logic [FRAMES_PER_PACKET-1:0] lane_ge;
    logic [HW-1:0]                lane_rem     [FRAMES_PER_PACKET];

    assign o_in_ready = (r_state == eeg_tpf_pkg::FR_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // A zero half period counts as one.
    assign divisor = (i_half_period == '0) ? HW'(1) : i_half_period;

    // Classify the accepted transaction and update the link flags.
    always_comb begin
        n_link_up      = r_link_up;
        n_streaming_on = r_streaming_on;
        tick_go        = 1'b0;
        req_push       = 1'b0;
        req_units      = i_fast_interval;
        if (accept) begin
            unique case (eeg_tpf_pkg::t_op'(i_operation))
                eeg_tpf_pkg::OP_TICK: begin
                    tick_go = r_link_up && r_streaming_on;
                end
                eeg_tpf_pkg::OP_COMMAND: begin
                    unique case (i_command_byte)
                        eeg_tpf_pkg::CMD_BEGIN: begin
                            n_streaming_on = 1'b1;
                            req_push       = r_link_up;
                            req_units      = i_fast_interval;
                        end
                        eeg_tpf_pkg::CMD_STOP: begin
                            n_streaming_on = 1'b0;
                            req_push       = r_link_up;
                            req_units      = i_idle_interval;
                        end
                        eeg_tpf_pkg::CMD_SLEEP: begin
                            n_streaming_on = 1'b0;
                            req_push       = r_link_up;
                            req_units      = i_sleep_interval;
                        end
                        default: begin
                        end
                    endcase
                end
                eeg_tpf_pkg::OP_CONNECT: begin
                    n_link_up = 1'b1;
                    req_push  = 1'b1;
                    req_units = i_fast_interval;
                end
                eeg_tpf_pkg::OP_DISCONNECT: begin
                    n_link_up      = 1'b0;
                    n_streaming_on = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_frame_sequence = tick_go ? r_frame_sequence + 8'd1 : r_frame_sequence;
    assign n_sample_count   = tick_go ? r_sample_count + CW'(FRAMES_PER_PACKET)
                                      : r_sample_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eeg_tpf_pkg::FR_IDLE: begin
                if (tick_go) n_state = eeg_tpf_pkg::FR_DIV;
            end
            eeg_tpf_pkg::FR_DIV: begin
                if (r_step == STEP_LAST) n_state = eeg_tpf_pkg::FR_PUSH;
            end
            eeg_tpf_pkg::FR_PUSH: begin
                if (!i_q_full) n_state = eeg_tpf_pkg::FR_IDLE;
            end
            default: n_state = eeg_tpf_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_push     = 1'b0;
        o_push_job = '0;
        unique case (r_state)
            eeg_tpf_pkg::FR_IDLE: begin
                if (req_push) begin
                    o_push                = 1'b1;
                    o_push_job.is_request = 1'b1;
                    o_push_job.units      = req_units;
                end
            end
            eeg_tpf_pkg::FR_PUSH: begin
                if (!i_q_full) begin
                    o_push                = 1'b1;
                    o_push_job.is_request = 1'b0;
                    o_push_job.seq        = r_seq_job;
                    o_push_job.odd        = MAXF'(r_odd);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= eeg_tpf_pkg::FR_IDLE;
            r_link_up        <= 1'b0;
            r_streaming_on   <= 1'b0;
            r_frame_sequence <= '0;
            r_sample_count   <= '0;
            r_step           <= '0;
        end else begin
            r_state          <= n_state;
            r_link_up        <= n_link_up;
            r_streaming_on   <= n_streaming_on;
            r_frame_sequence <= n_frame_sequence;
            r_sample_count   <= n_sample_count;
            if (tick_go) begin
                r_step <= '0;
            end else if (r_state == eeg_tpf_pkg::FR_DIV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) r_seq_job <= r_frame_sequence;
    end

    // One restoring divider lane per sample frame. Only the low quotient bit
    // is kept; it is the bit produced by the final step.
    always_comb begin
        for (int g = 0; g < FRAMES_PER_PACKET; g++) begin
            lane_partial[g] = {r_rem[g], r_dvd[g][CW-1]};
            lane_diff[g]    = lane_partial[g] - {1'b0, divisor};
            lane_ge[g]      = lane_partial[g] >= {1'b0, divisor};
            lane_rem[g]     = lane_ge[g] ? lane_diff[g][HW-1:0] : lane_partial[g][HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < FRAMES_PER_PACKET; g++) begin
            if (tick_go) begin
                r_dvd[g] <= r_sample_count + CW'(g + 1);
                r_rem[g] <= '0;
            end else if (r_state == eeg_tpf_pkg::FR_DIV) begin
                r_dvd[g] <= {r_dvd[g][CW-2:0], 1'b0};
                r_rem[g] <= lane_rem[g];
                r_odd[g] <= lane_ge[g];
            end
        end
    end

    `EEG_TPF_ASSERT_NEXT(a_tick_starts_div, tick_go, (r_state == eeg_tpf_pkg::FR_DIV) && (r_step == '0), "frame tick did not start the divider")
    `EEG_TPF_ASSERT_NOW(a_no_push_while_div, r_state == eeg_tpf_pkg::FR_DIV, !o_push && !o_in_ready, "front pushed or accepted during division")

endmodule

### design/eeg_tpf_queue.sv
// Short job queue between the front end and the emitter.
`include "eeg_test_packet_framer_assert.svh"

module eeg_tpf_queue #(
    parameter int DEPTH = eeg_tpf_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eeg_tpf_pkg::t_job i_push_job,
    input  logic              i_pop,
    output eeg_tpf_pkg::t_job o_head_job,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    eeg_tpf_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_full     = r_count == CNT_W'(DEPTH);
    assign o_empty    = r_count == '0;
    assign o_head_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_push_job;
    end

    `EEG_TPF_ASSERT_NOW(a_no_overflow, i_push, !o_full, "job pushed into a full queue")
    `EEG_TPF_ASSERT_NOW(a_no_underflow, i_pop, !o_empty, "job popped from an empty queue")

endmodule

### design/eeg_tpf_back.sv
// Emitter: turns queued jobs into output transactions, one byte per cycle while the output accepts them.
`include "eeg_test_packet_framer_assert.svh"

module eeg_tpf_back #(
    parameter int CHANNELS          = eeg_tpf_pkg::CHANNELS_DEF,
    parameter int FRAMES_PER_PACKET = eeg_tpf_pkg::FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  eeg_tpf_pkg::t_job                i_q_job,
    output logic                             o_pop,
    input  logic [eeg_tpf_pkg::AMP_W-1:0]    i_amplitude,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [7:0]                       o_data_byte,
    output logic [eeg_tpf_pkg::UNITS_W-1:0]  o_interval_units,
    output logic                             o_last
);

    localparam int SW          = eeg_tpf_pkg::SAMPLE_W;
    localparam int UW          = eeg_tpf_pkg::UNITS_W;
    localparam int MAXF        = eeg_tpf_pkg::MAX_FRAMES;
    localparam int FRAME_BYTES = 4 + 3 * CHANNELS * FRAMES_PER_PACKET;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int F_W         = $clog2(MAXF);
    localparam logic [IDX_W-1:0] IDX_SEQ  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_SUM  = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_TAIL = IDX_W'(FRAME_BYTES - 1);

    eeg_tpf_pkg::t_back_state r_state, n_state;

    logic [IDX_W-1:0] r_idx;
    logic [CH_W-1:0]  r_ch;
    logic [F_W-1:0]   r_f;
    logic [1:0]       r_b;
    logic [7:0]       r_sum;
    logic [7:0]       r_seq;
    logic [MAXF-1:0]  r_odd;

    logic          r_out_valid, r_kind, r_last;
    logic [7:0]    r_data;
    logic [UW-1:0] r_units;
    logic          n_kind, n_last;
    logic [7:0]    n_data;
    logic [UW-1:0] n_units;

    logic          advance;
    logic          out_load;
    logic          start_frame;
    logic          frame_step;
    logic          is_sample;
    logic [SW-1:0] pos, neg, lane_val, smp;
    logic [7:0]    smp_byte, frame_byte;

    assign advance = !r_out_valid || i_out_ready;

    // Square wave sample for the current frame and channel.
    always_comb begin
        pos      = {1'b0, i_amplitude};
        neg      = -pos;
        lane_val = r_odd[r_f] ? neg : pos;
        smp      = (32'(r_ch) >= 32'(eeg_tpf_pkg::NEG_FIRST_CH)) ? -lane_val : lane_val;
        unique case (r_b)
            2'd0:    smp_byte = smp[SW-1:SW-8];
            2'd1:    smp_byte = smp[SW-9:SW-16];
            default: smp_byte = smp[SW-17:0];
        endcase
    end

    always_comb begin
        is_sample  = 1'b0;
        frame_byte = smp_byte;
        if (r_idx == IDX_SEQ) begin
            frame_byte = r_seq;
        end else if (r_idx == IDX_SUM) begin
            frame_byte = r_sum;
        end else if (r_idx == IDX_TAIL) begin
            frame_byte = eeg_tpf_pkg::FRAME_TAIL;
        end else begin
            is_sample = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eeg_tpf_pkg::BK_IDLE: begin
                if (advance && !i_q_empty && !i_q_job.is_request) begin
                    n_state = eeg_tpf_pkg::BK_FRAME;
                end
            end
            eeg_tpf_pkg::BK_FRAME: begin
                if (advance && (r_idx == IDX_TAIL)) n_state = eeg_tpf_pkg::BK_IDLE;
            end
            default: n_state = eeg_tpf_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        out_load    = 1'b0;
        start_frame = 1'b0;
        frame_step  = 1'b0;
        n_kind      = eeg_tpf_pkg::KIND_FRAME;
        n_data      = '0;
        n_units     = '0;
        n_last      = 1'b0;
        unique case (r_state)
            eeg_tpf_pkg::BK_IDLE: begin
                if (advance && !i_q_empty) begin
                    o_pop    = 1'b1;
                    out_load = 1'b1;
                    if (i_q_job.is_request) begin
                        n_kind  = eeg_tpf_pkg::KIND_REQUEST;
                        n_units = i_q_job.units;
                        n_last  = 1'b1;
                    end else begin
                        start_frame = 1'b1;
                        n_data      = eeg_tpf_pkg::FRAME_HEAD;
                    end
                end
            end
            eeg_tpf_pkg::BK_FRAME: begin
                if (advance) begin
                    out_load   = 1'b1;
                    frame_step = 1'b1;
                    n_data     = frame_byte;
                    n_last     = r_idx == IDX_TAIL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eeg_tpf_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_units <= n_units;
            r_last  <= n_last;
        end
        if (start_frame) begin
            r_seq <= i_q_job.seq;
            r_odd <= i_q_job.odd;
            r_idx <= IDX_SEQ;
            r_ch  <= '0;
            r_f   <= '0;
            r_b   <= '0;
            r_sum <= '0;
        end else if (frame_step) begin
            r_idx <= r_idx + 1'b1;
            if (is_sample) begin
                r_sum <= r_sum + smp_byte;
                if (r_b == 2'd2) begin
                    r_b <= '0;
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        r_ch <= '0;
                        r_f  <= r_f + 1'b1;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end else begin
                    r_b <= r_b + 1'b1;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_interval_units = r_units;
    assign o_last           = r_last;

    `EEG_TPF_ASSERT_NOW(a_idx_in_frame, r_state == eeg_tpf_pkg::BK_FRAME, (r_idx != '0) && (32'(r_idx) < 32'(FRAME_BYTES)), "frame byte index out of range")

endmodule

### design/eeg_test_packet_framer.sv
// Top level of the EEG test packet framer: configuration registers and the job pipeline.

// The framer takes four kinds of input transaction (timer tick, command byte,
// link connect, link disconnect) and produces output transactions that are
// either single connection interval requests or the bytes of a test frame.
// Connect, and the commands 'b', 's' and 'd' while the link is up, give one
// request transaction, marked last. A tick while the link is up and streaming
// is on gives a frame of 4 + 3 * CHANNELS * FRAMES_PER_PACKET bytes (52 with
// the default parameters): 0xA0, the sequence byte, the big-endian 24-bit
// square wave samples, their 8-bit sum, and 0xC0 marked last. Non-tick items
// are accepted back to back, one per cycle, as long as the two-entry job queue
// has room. A frame tick keeps the front end busy while it accepts the tick,
// runs the bit-serial divider that finds which half period each sample falls
// in, and queues the job, waiting while the queue is full. The emitter sends
// one byte per cycle while the output is ready, and it runs while the front
// end takes the next transactions. The output is registered, so a stalled
// output never blocks the input side until the queue fills. Configuration
// writes are always accepted and must only be issued while the block is idle.
module eeg_test_packet_framer #(
    parameter int CHANNELS          = eeg_tpf_pkg::CHANNELS_DEF,
    parameter int FRAMES_PER_PACKET = eeg_tpf_pkg::FRAMES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input item channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_operation,
    input  logic [7:0]                            i_command_byte,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_kind,
    output logic [7:0]                            o_data_byte,
    output logic [eeg_tpf_pkg::UNITS_W-1:0]       o_interval_units,
    output logic                                  o_last,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [eeg_tpf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [eeg_tpf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int UW = eeg_tpf_pkg::UNITS_W;

    // Configuration registers, read live by both halves of the pipeline; this is
    // safe only if the user writes them while idle, which the block does not enforce.
    logic [eeg_tpf_pkg::AMP_W-1:0] r_amplitude;
    logic [eeg_tpf_pkg::HP_W-1:0]  r_half_period;
    logic [UW-1:0]                 r_fast_interval;
    logic [UW-1:0]                 r_idle_interval;
    logic [UW-1:0]                 r_sleep_interval;

    logic              q_push, q_pop, q_full, q_empty;
    eeg_tpf_pkg::t_job push_job, head_job;

    assign o_cfg_ready = 1'b1;

    // A write to an index beyond the register list is accepted and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude      <= eeg_tpf_pkg::AMPLITUDE_RST;
            r_half_period    <= eeg_tpf_pkg::HALF_PERIOD_RST;
            r_fast_interval  <= eeg_tpf_pkg::FAST_INTERVAL_RST;
            r_idle_interval  <= eeg_tpf_pkg::IDLE_INTERVAL_RST;
            r_sleep_interval <= eeg_tpf_pkg::SLEEP_INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                eeg_tpf_pkg::CFG_AMPLITUDE:      r_amplitude      <= i_cfg_data;
                eeg_tpf_pkg::CFG_HALF_PERIOD:    r_half_period    <= i_cfg_data[7:0];
                eeg_tpf_pkg::CFG_FAST_INTERVAL:  r_fast_interval  <= i_cfg_data[UW-1:0];
                eeg_tpf_pkg::CFG_IDLE_INTERVAL:  r_idle_interval  <= i_cfg_data[UW-1:0];
                eeg_tpf_pkg::CFG_SLEEP_INTERVAL: r_sleep_interval <= i_cfg_data[UW-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end owns the link, streaming, sequence and sample state and
    // hands finished jobs to the queue in transaction order.
    eeg_tpf_front #(
        .FRAMES_PER_PACKET (FRAMES_PER_PACKET)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_command_byte   (i_command_byte),
        .i_half_period    (r_half_period),
        .i_fast_interval  (r_fast_interval),
        .i_idle_interval  (r_idle_interval),
        .i_sleep_interval (r_sleep_interval),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_push_job       (push_job)
    );

    eeg_tpf_queue #(
        .DEPTH (eeg_tpf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (push_job),
        .i_pop      (q_pop),
        .o_head_job (head_job),
        .o_full     (q_full),
        .o_empty    (q_empty)
    );

    // The emitter drains jobs and serializes frames into the output register.
    eeg_tpf_back #(
        .CHANNELS          (CHANNELS),
        .FRAMES_PER_PACKET (FRAMES_PER_PACKET)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_job          (head_job),
        .o_pop            (q_pop),
        .i_amplitude      (r_amplitude),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_interval_units (o_interval_units),
        .o_last           (o_last)
    );

endmodule
